### src/mmn_pkg.sv
`timescale 1ns / 1ps
package mmn_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int LEVEL_BITS  = 8;
  localparam int REM_W       = SAMPLE_BITS + LEVEL_BITS;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
  localparam int STEP_W      = $clog2(LEVEL_BITS);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [LEVEL_BITS-1:0] LEVEL_TOP = {LEVEL_BITS{1'b1}};

  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,
    KIND_TOP  = 2'd1,
    KIND_DIV  = 2'd2
  } conv_kind_t;

  typedef struct packed {
    logic                          mode;
    logic                          restart;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_in;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] level;
    logic                  last_out;
  } out_item_t;

  typedef struct packed {
    conv_kind_t             kind;
    logic [SAMPLE_BITS-1:0] off;
    logic [SAMPLE_BITS-1:0] span;
    logic                   last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### src/mmn_front.sv
`timescale 1ns / 1ps
module mmn_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mmn_pkg::in_item_t in_data,
  input  mmn_pkg::q_status_t q_status,
  output logic             q_push,
  output mmn_pkg::job_t    q_job
);
  import mmn_pkg::*;

  logic signed [SAMPLE_BITS-1:0] lowest_r, lowest_nxt;
  logic signed [SAMPLE_BITS-1:0] highest_r, highest_nxt;
  logic                          any_r, any_nxt;
  logic signed [SAMPLE_BITS-1:0] base_low, base_high;
  logic signed [SAMPLE_BITS:0]   span_wide, off_wide;
  logic                          accept;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    base_low    = in_data.restart ? SAMPLE_MAX : lowest_r;
    base_high   = in_data.restart ? SAMPLE_MIN : highest_r;
    lowest_nxt  = lowest_r;
    highest_nxt = highest_r;
    any_nxt     = any_r;
    if (accept && !in_data.mode) begin
      lowest_nxt  = (in_data.sample < base_low) ? in_data.sample : base_low;
      highest_nxt = (in_data.sample > base_high) ? in_data.sample : base_high;
      any_nxt     = 1'b1;
    end
  end

  always_comb begin
    span_wide  = {highest_r[SAMPLE_BITS-1], highest_r} - {lowest_r[SAMPLE_BITS-1], lowest_r};
    off_wide   = {in_data.sample[SAMPLE_BITS-1], in_data.sample}
               - {lowest_r[SAMPLE_BITS-1], lowest_r};
    q_job.span = span_wide[SAMPLE_BITS-1:0];
    q_job.off  = off_wide[SAMPLE_BITS-1:0];
    q_job.last = in_data.last_in;
    if (!any_r || highest_r <= lowest_r || in_data.sample <= lowest_r) begin
      q_job.kind = KIND_ZERO;
    end else if (in_data.sample >= highest_r) begin
      q_job.kind = KIND_TOP;
    end else begin
      q_job.kind = KIND_DIV;
    end
  end

  assign q_push = accept && in_data.mode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowest_r  <= SAMPLE_MAX;
      highest_r <= SAMPLE_MIN;
      any_r     <= 1'b0;
    end else begin
      lowest_r  <= lowest_nxt;
      highest_r <= highest_nxt;
      any_r     <= any_nxt;
    end
  end

endmodule

### src/mmn_queue.sv
`timescale 1ns / 1ps
module mmn_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mmn_pkg::job_t      push_job,
  input  logic               pop,
  output mmn_pkg::job_t      head_job,
  output mmn_pkg::q_status_t status
);
  import mmn_pkg::*;

  job_t               slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign status.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head_job     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= Q_CNT_W'(Q_DEPTH))
    else $error("queue count above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != Q_CNT_W'(Q_DEPTH) && count_r != '0) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

### src/mmn_back.sv
`timescale 1ns / 1ps
module mmn_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mmn_pkg::job_t      head_job,
  input  mmn_pkg::q_status_t q_status,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output mmn_pkg::out_item_t out_data
);
  import mmn_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } back_state_t;

  back_state_t           state_r, state_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [REM_W-1:0]      div_r, div_nxt;
  logic [LEVEL_BITS-1:0] quot_r, quot_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic                  last_r, last_nxt;
  logic [REM_W-1:0]      dividend;
  logic                  fits;

  assign dividend = {head_job.off, {LEVEL_BITS{1'b0}}} - REM_W'(head_job.off);
  assign fits     = (rem_r >= div_r);
  assign q_pop    = (state_r == ST_IDLE) && !q_status.empty;

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    quot_nxt  = quot_r;
    step_nxt  = step_r;
    last_nxt  = last_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_status.empty) begin
          last_nxt = head_job.last;
          rem_nxt  = dividend;
          div_nxt  = {{(REM_W-SAMPLE_BITS-LEVEL_BITS+1){1'b0}}, head_job.span,
                      {(LEVEL_BITS-1){1'b0}}};
          step_nxt = STEP_W'(LEVEL_BITS - 1);
          case (head_job.kind)
            KIND_DIV: begin
              quot_nxt  = '0;
              state_nxt = ST_DIV;
            end
            KIND_TOP: begin
              quot_nxt  = LEVEL_TOP;
              state_nxt = ST_OUT;
            end
            default: begin
              quot_nxt  = '0;
              state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_nxt  = fits ? rem_r - div_r : rem_r;
        div_nxt  = div_r >> 1;
        quot_nxt = {quot_r[LEVEL_BITS-2:0], fits};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    quot_r <= quot_nxt;
    step_r <= step_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign out_valid         = (state_r == ST_OUT);
  assign out_data.level    = quot_r;
  assign out_data.last_out = last_r;

  a_rem_below_double: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < (div_r << 1)))
    else $error("divider remainder out of range");

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == ST_DIV || state_r == ST_OUT))
    else $error("pop did not start a job");

  a_div_ends_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && step_r == '0) |=> (state_r == ST_OUT))
    else $error("divide did not finish after last step");

endmodule

### src/min_max_normalize_to_byte_top.sv
`timescale 1ns / 1ps
// min/max normalization of signed samples to bytes
// input channel: in_valid / in_stall / in_data (mode, restart, sample, last_in)
// output channel: out_valid / out_stall / out_data (level, last_out)
// stream the volume once with mode 0 to gather the extrema (restart on the
// first item clears them), then again with mode 1 to get one byte per item
// scan items give no output and are accepted one per cycle, never stalled unless
// the job queue is full
// convert items go through a four-entry job queue to a serial restoring
// divider that makes one quotient bit per cycle: a dividing item passes
// through pop, 8 steps and output in the back end, a saturated or flat
// item through pop and output; the back end pops only while idle
// when out_stall is high the result holds and the back end waits; the front
// keeps accepting until the queue fills, then raises in_stall
// synchronous active-low reset clears the extrema to their empty values,
// empties the queue and drops out_valid
module min_max_normalize_to_byte_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mmn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mmn_pkg::out_item_t out_data
);
  import mmn_pkg::*;

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  job_t      push_job;
  job_t      head_job;

  mmn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_status (q_status),
    .q_push   (q_push),
    .q_job    (push_job)
  );

  mmn_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .status   (q_status)
  );

  mmn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
